// ----- design/cdt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package cdt_pkg;

  // Field widths of the command and result words.
  localparam int CMD_W   = 3;
  localparam int HDL_W   = 16;
  localparam int TIME_W  = 32;
  localparam int POS_W   = 6;
  localparam int STAT_W  = 3;
  localparam int TMO_W   = 32;

  // Most entries one sweep may remove.
  localparam int MAX_RESULTS = 32;
  localparam int NRES_W      = $clog2(MAX_RESULTS + 1);

  // Seconds to milliseconds, and the product width of that scaling.
  localparam int MS_PER_S = 1000;
  localparam int PROD_W   = TIME_W + 10;

  localparam logic signed [TMO_W-1:0] TIMEOUT_TOP = 32'sh7FFF_FFFF;
  localparam logic signed [TMO_W-1:0] TMO_EMPTY   = -32'sd1;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_ADD       = 3'd0;
  localparam logic [CMD_W-1:0] CMD_RM_HANDLE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_NEAREST   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_SWEEP     = 3'd3;
  localparam logic [CMD_W-1:0] CMD_RM_AT     = 3'd4;

  // Status codes.
  localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
  localparam logic [STAT_W-1:0] ST_FULL      = 3'd1;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd2;
  localparam logic [STAT_W-1:0] ST_EMPTY     = 3'd3;
  localparam logic [STAT_W-1:0] ST_NONE_EXP  = 3'd4;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [HDL_W-1:0]  handle;
    logic [TIME_W-1:0] deadline;
    logic [TIME_W-1:0] now;
    logic [POS_W-1:0]  position;
  } in_word_t;

  typedef struct packed {
    logic [STAT_W-1:0]        status;
    logic [HDL_W-1:0]         found_handle;
    logic [TIME_W-1:0]        found_deadline;
    logic signed [TMO_W-1:0]  wait_ms;
    logic                     last;
  } out_word_t;

  // One slot of the table.
  typedef struct packed {
    logic [HDL_W-1:0]  handle;
    logic [TIME_W-1:0] deadline;
  } entry_t;

  // Flags of the shared compare unit.
  typedef struct packed {
    logic lt;
    logic le;
  } alu_flags_t;

endpackage

`default_nettype wire

// ----- design/connection_deadline_table.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Packed table of connection handles with deadlines in seconds.
// Input channel: in_valid / in_stall / in_word carries one command word
// (add, remove by handle, nearest timeout, sweep expired, remove at slot).
// Output channel: out_valid / out_stall / out_word carries result words;
// the final word of a command has last set. Only sweep gives several.
// One command is worked at a time; in_stall is high until it has queued
// its final word. Every walk goes through the single table read port,
// which visits one slot a cycle unless a sweep waits on the output.
// A finished word waits in the output register while the next command
// is accepted; a stalled receiver holds the sequencer at its next word.
// Reset empties the table at once (live count to zero); stored slots are
// not cleared because only live slots are ever read.
module connection_deadline_table #(
  parameter int CAPACITY = 32
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire cdt_pkg::in_word_t  in_word,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output cdt_pkg::out_word_t      out_word
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic                         mem_we;
  logic [IDX_W-1:0]             mem_waddr;
  cdt_pkg::entry_t              mem_wdata;
  logic                         mem_re;
  logic [IDX_W-1:0]             mem_raddr;
  cdt_pkg::entry_t              mem_rdata_r;
  logic [cdt_pkg::TIME_W-1:0]   alu_a;
  logic [cdt_pkg::TIME_W-1:0]   alu_b;
  cdt_pkg::alu_flags_t          alu_flags;
  logic [cdt_pkg::TIME_W-1:0]   alu_diff;

  cdt_pkg::entry_t              tbl_mem [0:CAPACITY-1];

  // Entry store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      tbl_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_r <= tbl_mem[mem_raddr];
    end
  end

  cdt_alu u_alu (
    .a     (alu_a),
    .b     (alu_b),
    .flags (alu_flags),
    .diff  (alu_diff)
  );

  cdt_seq #(
    .CAPACITY (CAPACITY),
    .CNT_W    (CNT_W),
    .IDX_W    (IDX_W)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata_r),
    .alu_a     (alu_a),
    .alu_b     (alu_b),
    .alu_flags (alu_flags),
    .alu_diff  (alu_diff)
  );

endmodule

`default_nettype wire

// ----- design/cdt_alu.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Shared time comparator and subtractor: a against b, unsigned.
module cdt_alu (
  input  wire logic [cdt_pkg::TIME_W-1:0] a,
  input  wire logic [cdt_pkg::TIME_W-1:0] b,
  output cdt_pkg::alu_flags_t             flags,
  output logic [cdt_pkg::TIME_W-1:0]      diff
);

  logic [cdt_pkg::TIME_W:0] sub;

  // One wide subtract gives both the gap and the borrow.
  assign sub      = {1'b0, a} - {1'b0, b};
  assign diff     = sub[cdt_pkg::TIME_W-1:0];
  assign flags.lt = sub[cdt_pkg::TIME_W];
  assign flags.le = sub[cdt_pkg::TIME_W] | (a == b);

endmodule

`default_nettype wire

// ----- design/cdt_seq.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Sequencer: decodes a command word, walks the table one slot a cycle (a sweep
// pauses while its word waits) through the memory read port and drives the shared compare unit.
module cdt_seq #(
  parameter int CAPACITY = 32,
  parameter int CNT_W    = $clog2(CAPACITY + 1),
  parameter int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire cdt_pkg::in_word_t            in_word,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output cdt_pkg::out_word_t                out_word,
  output logic                              mem_we,
  output logic [IDX_W-1:0]                  mem_waddr,
  output cdt_pkg::entry_t                   mem_wdata,
  output logic                              mem_re,
  output logic [IDX_W-1:0]                  mem_raddr,
  input  wire cdt_pkg::entry_t              mem_rdata,
  output logic [cdt_pkg::TIME_W-1:0]        alu_a,
  output logic [cdt_pkg::TIME_W-1:0]        alu_b,
  input  wire cdt_pkg::alu_flags_t          alu_flags,
  input  wire logic [cdt_pkg::TIME_W-1:0]   alu_diff
);

  localparam int ST_W = 4;
  localparam logic [ST_W-1:0] S_IDLE   = 4'd0;
  localparam logic [ST_W-1:0] S_SRCH   = 4'd1;
  localparam logic [ST_W-1:0] S_FETCH  = 4'd2;
  localparam logic [ST_W-1:0] S_MOVE   = 4'd3;
  localparam logic [ST_W-1:0] S_MIN    = 4'd4;
  localparam logic [ST_W-1:0] S_CMPNOW = 4'd5;
  localparam logic [ST_W-1:0] S_MUL    = 4'd6;
  localparam logic [ST_W-1:0] S_SAT    = 4'd7;
  localparam logic [ST_W-1:0] S_SWP    = 4'd8;
  localparam logic [ST_W-1:0] S_SLAST  = 4'd9;
  localparam logic [ST_W-1:0] S_SFIN   = 4'd10;
  localparam logic [ST_W-1:0] S_EMIT   = 4'd11;

  logic [ST_W-1:0]                state_r, state_nxt;
  logic [ST_W-1:0]                ret_r, ret_nxt;
  logic [CNT_W-1:0]               count_r, count_nxt;
  logic [IDX_W-1:0]               idx_r, idx_nxt;
  logic [cdt_pkg::NRES_W-1:0]     n_r, n_nxt;
  logic                           pend_valid_r, pend_valid_nxt;
  cdt_pkg::entry_t                pend_r, pend_nxt;
  logic [cdt_pkg::TIME_W-1:0]     min_r, min_nxt;
  logic [cdt_pkg::TIME_W-1:0]     diff_r, diff_nxt;
  logic [cdt_pkg::PROD_W-1:0]     prod_r, prod_nxt;
  cdt_pkg::in_word_t              cmd_r, cmd_nxt;
  cdt_pkg::out_word_t             res_r, res_nxt;
  logic                           out_valid_r, out_valid_nxt;
  cdt_pkg::out_word_t             out_word_r, out_word_nxt;

  logic                           idx_is_last;
  logic [IDX_W-1:0]               last_idx;
  logic [IDX_W-1:0]               idx_inc;
  logic                           out_free;
  logic [ST_W-1:0]                swp_next;

  // Position helpers for the walk.
  assign idx_is_last = (CNT_W'(idx_r) == (count_r - CNT_W'(1)));
  assign last_idx    = IDX_W'(count_r - CNT_W'(1));
  assign idx_inc     = idx_r + IDX_W'(1);
  assign out_free    = !out_valid_r || !out_stall;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // Operand selection for the shared compare unit.
  always_comb begin
    alu_a = mem_rdata.deadline;
    alu_b = cmd_r.now;
    unique case (state_r)
      S_MIN: begin
        alu_b = min_r;
      end
      S_CMPNOW: begin
        alu_a = min_r;
      end
      default: begin
        alu_a = mem_rdata.deadline;
      end
    endcase
  end

  // Next-state and datapath control.
  always_comb begin
    state_nxt      = state_r;
    ret_nxt        = ret_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    n_nxt          = n_r;
    pend_valid_nxt = pend_valid_r;
    pend_nxt       = pend_r;
    min_nxt        = min_r;
    diff_nxt       = diff_r;
    prod_nxt       = prod_r;
    cmd_nxt        = cmd_r;
    res_nxt        = res_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_word_nxt   = out_word_r;
    mem_we         = 1'b0;
    mem_waddr      = idx_r;
    mem_wdata      = mem_rdata;
    mem_re         = 1'b0;
    mem_raddr      = idx_inc;
    swp_next       = S_SFIN;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt          = in_word;
          res_nxt          = '0;
          res_nxt.last     = 1'b1;
          ret_nxt          = S_IDLE;
          idx_nxt          = '0;
          state_nxt        = S_EMIT;
          mem_raddr        = '0;
          unique case (in_word.command)
            cdt_pkg::CMD_ADD: begin
              if (count_r >= CNT_W'(CAPACITY)) begin
                res_nxt.status = cdt_pkg::ST_FULL;
              end else begin
                mem_we             = 1'b1;
                mem_waddr          = IDX_W'(count_r);
                mem_wdata.handle   = in_word.handle;
                mem_wdata.deadline = in_word.deadline;
                count_nxt          = count_r + CNT_W'(1);
                res_nxt.status     = cdt_pkg::ST_OK;
              end
            end
            cdt_pkg::CMD_RM_HANDLE: begin
              if (count_r == '0) begin
                res_nxt.status = cdt_pkg::ST_NOT_FOUND;
              end else begin
                mem_re    = 1'b1;
                state_nxt = S_SRCH;
              end
            end
            cdt_pkg::CMD_NEAREST: begin
              if (count_r == '0) begin
                res_nxt.status  = cdt_pkg::ST_EMPTY;
                res_nxt.wait_ms = cdt_pkg::TMO_EMPTY;
              end else begin
                mem_re    = 1'b1;
                state_nxt = S_MIN;
              end
            end
            cdt_pkg::CMD_SWEEP: begin
              n_nxt          = '0;
              pend_valid_nxt = 1'b0;
              if (count_r == '0) begin
                res_nxt.status = cdt_pkg::ST_NONE_EXP;
              end else begin
                mem_re    = 1'b1;
                state_nxt = S_SWP;
              end
            end
            cdt_pkg::CMD_RM_AT: begin
              if ({1'b0, in_word.position} >=
                  (cdt_pkg::POS_W + 1)'(count_r)) begin
                res_nxt.status = cdt_pkg::ST_NOT_FOUND;
              end else begin
                idx_nxt   = IDX_W'(in_word.position);
                mem_re    = 1'b1;
                mem_raddr = IDX_W'(in_word.position);
                state_nxt = S_FETCH;
              end
            end
            default: begin
              res_nxt.status = cdt_pkg::ST_NOT_FOUND;
            end
          endcase
        end
      end

      // Linear search for the handle, one slot per cycle.
      S_SRCH: begin
        if (mem_rdata.handle == cmd_r.handle) begin
          res_nxt.status         = cdt_pkg::ST_OK;
          res_nxt.found_handle   = mem_rdata.handle;
          res_nxt.found_deadline = mem_rdata.deadline;
          mem_re                 = 1'b1;
          mem_raddr              = last_idx;
          state_nxt              = S_MOVE;
        end else if (idx_is_last) begin
          res_nxt.status = cdt_pkg::ST_NOT_FOUND;
          state_nxt      = S_EMIT;
        end else begin
          mem_re  = 1'b1;
          idx_nxt = idx_inc;
        end
      end

      S_FETCH: begin
        res_nxt.status         = cdt_pkg::ST_OK;
        res_nxt.found_handle   = mem_rdata.handle;
        res_nxt.found_deadline = mem_rdata.deadline;
        mem_re                 = 1'b1;
        mem_raddr              = last_idx;
        state_nxt              = S_MOVE;
      end

      // The last entry fills the freed slot.
      S_MOVE: begin
        mem_we    = 1'b1;
        count_nxt = count_r - CNT_W'(1);
        state_nxt = S_EMIT;
      end

      // Running minimum over all live deadlines.
      S_MIN: begin
        if (idx_r == '0 || alu_flags.lt) begin
          min_nxt = mem_rdata.deadline;
        end
        if (idx_is_last) begin
          state_nxt = S_CMPNOW;
        end else begin
          mem_re  = 1'b1;
          idx_nxt = idx_inc;
        end
      end

      S_CMPNOW: begin
        if (alu_flags.le) begin
          res_nxt.status  = cdt_pkg::ST_OK;
          res_nxt.wait_ms = '0;
          state_nxt       = S_EMIT;
        end else begin
          diff_nxt  = alu_diff;
          state_nxt = S_MUL;
        end
      end

      S_MUL: begin
        prod_nxt  = cdt_pkg::PROD_W'(diff_r) * cdt_pkg::PROD_W'(cdt_pkg::MS_PER_S);
        state_nxt = S_SAT;
      end

      // Clamp the millisecond gap to the largest positive value.
      S_SAT: begin
        res_nxt.status = cdt_pkg::ST_OK;
        if (|prod_r[cdt_pkg::PROD_W-1:cdt_pkg::TMO_W-1]) begin
          res_nxt.wait_ms = cdt_pkg::TIMEOUT_TOP;
        end else begin
          res_nxt.wait_ms = signed'(prod_r[cdt_pkg::TMO_W-1:0]);
        end
        state_nxt = S_EMIT;
      end

      // Sweep: an expired entry is held back one step so that the
      // final word can carry the last flag.
      S_SWP: begin
        if (alu_flags.le) begin
          n_nxt                  = n_r + cdt_pkg::NRES_W'(1);
          res_nxt.status         = cdt_pkg::ST_OK;
          res_nxt.found_handle   = pend_r.handle;
          res_nxt.found_deadline = pend_r.deadline;
          res_nxt.wait_ms        = '0;
          res_nxt.last           = 1'b0;
          pend_nxt               = mem_rdata;
          pend_valid_nxt         = 1'b1;
          if (idx_is_last) begin
            count_nxt = count_r - CNT_W'(1);
            swp_next  = S_SFIN;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = last_idx;
            swp_next  = S_SLAST;
          end
          if (pend_valid_r) begin
            ret_nxt   = swp_next;
            state_nxt = S_EMIT;
          end else begin
            state_nxt = swp_next;
          end
        end else if (idx_is_last) begin
          state_nxt = S_SFIN;
        end else begin
          mem_re  = 1'b1;
          idx_nxt = idx_inc;
        end
      end

      // The last entry moves in and is checked again from the read data.
      S_SLAST: begin
        mem_we    = 1'b1;
        count_nxt = count_r - CNT_W'(1);
        if (n_r == cdt_pkg::NRES_W'(cdt_pkg::MAX_RESULTS)) begin
          state_nxt = S_SFIN;
        end else begin
          state_nxt = S_SWP;
        end
      end

      S_SFIN: begin
        res_nxt      = '0;
        res_nxt.last = 1'b1;
        if (pend_valid_r) begin
          res_nxt.status         = cdt_pkg::ST_OK;
          res_nxt.found_handle   = pend_r.handle;
          res_nxt.found_deadline = pend_r.deadline;
        end else begin
          res_nxt.status = cdt_pkg::ST_NONE_EXP;
        end
        ret_nxt   = S_IDLE;
        state_nxt = S_EMIT;
      end

      // Hand the pending word to the output register.
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = res_r;
          state_nxt     = ret_r;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      ret_r        <= S_IDLE;
      count_r      <= '0;
      n_r          <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      ret_r        <= ret_nxt;
      count_r      <= count_nxt;
      n_r          <= n_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    pend_r     <= pend_nxt;
    min_r      <= min_nxt;
    diff_r     <= diff_nxt;
    prod_r     <= prod_nxt;
    cmd_r      <= cmd_nxt;
    res_r      <= res_nxt;
    out_word_r <= out_word_nxt;
  end

  // The live count never passes the table size.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("live count above capacity");

  // The live count moves by at most one entry per cycle.
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && (count_r != $past(count_r)) |->
      (count_r == $past(count_r) + CNT_W'(1)) ||
      (count_r == $past(count_r) - CNT_W'(1)))
    else $error("live count jumped");

  // A word that is not final can only come from a sweep.
  a_nonlast_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_word_r.last |-> cmd_r.command == cdt_pkg::CMD_SWEEP)
    else $error("non-final word outside a sweep");

  // A sweep never removes more than its limit.
  a_sweep_limit: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= cdt_pkg::NRES_W'(cdt_pkg::MAX_RESULTS))
    else $error("sweep removal count above limit");

endmodule

`default_nettype wire

// ----- test/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

  localparam int CAPACITY     = 32;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int HOLD_LEN     = 300;
  localparam int DRAIN_CYCLES = 120;
  localparam int HANDLE_POOL  = 15;

  // Command codes the block does not define; they must report not found.
  localparam logic [cdt_pkg::CMD_W-1:0] CMD_SPARE_LO = 3'd5;
  localparam logic [cdt_pkg::CMD_W-1:0] CMD_SPARE_HI = 3'd7;

  localparam logic [cdt_pkg::TIME_W-1:0] TIME_MAX = '1;
  localparam logic [cdt_pkg::HDL_W-1:0]  HDL_MAX  = '1;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  cdt_pkg::in_word_t  in_word   = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  cdt_pkg::out_word_t out_word;

  connection_deadline_table #(
    .CAPACITY(CAPACITY)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word)
  );

  // Command words waiting to be driven, and result words still owed by the block.
  cdt_pkg::in_word_t  cmd_queue[$];
  cdt_pkg::out_word_t expected_words[$];

  // Shadow copy of the connection table.
  logic [cdt_pkg::HDL_W-1:0]  tbl_handle[CAPACITY];
  logic [cdt_pkg::TIME_W-1:0] tbl_deadline[CAPACITY];
  int unsigned                tbl_count = 0;

  int   mismatch_count = 0;
  int   cycle_count    = 0;
  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  int   hold_req       = 0;
  int   hold_seen      = 0;
  int   hold_left      = 0;
  logic in_taken       = 1'b0;
  logic [cdt_pkg::TIME_W-1:0] sim_now = 32'd1000;

  initial begin
    forever #5 clk = ~clk;
  end

  // Give up if the run goes on far longer than any correct run could.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic flag_error(input string msg);
    mismatch_count++;
    $display("ERROR cycle %0d: %s", cycle_count, msg);
  endtask

  function automatic cdt_pkg::out_word_t result_word(
      input logic [cdt_pkg::STAT_W-1:0]       st,
      input logic [cdt_pkg::HDL_W-1:0]        h,
      input logic [cdt_pkg::TIME_W-1:0]       d,
      input logic signed [cdt_pkg::TMO_W-1:0] tmo,
      input logic                             is_last);
    cdt_pkg::out_word_t w;
    w.status         = st;
    w.found_handle   = h;
    w.found_deadline = d;
    w.wait_ms        = tmo;
    w.last           = is_last;
    return w;
  endfunction

  // Move the last live entry into the freed slot and shrink the table.
  task automatic vacate(input int unsigned slot);
    tbl_handle[slot]   = tbl_handle[tbl_count - 1];
    tbl_deadline[slot] = tbl_deadline[tbl_count - 1];
    tbl_count--;
  endtask

  task automatic remove_entry(input int unsigned slot);
    expected_words.push_back(result_word(cdt_pkg::ST_OK, tbl_handle[slot],
                                         tbl_deadline[slot], '0, 1'b1));
    vacate(slot);
  endtask

  // Apply one accepted command to the shadow table and queue the words it owes.
  task automatic table_apply(input cdt_pkg::in_word_t w);
    logic [cdt_pkg::HDL_W-1:0]        swept_h[cdt_pkg::MAX_RESULTS];
    logic [cdt_pkg::TIME_W-1:0]       swept_d[cdt_pkg::MAX_RESULTS];
    logic [cdt_pkg::TIME_W-1:0]       earliest;
    logic [63:0]                      gap_ms;
    logic signed [cdt_pkg::TMO_W-1:0] tmo;
    int unsigned                      slot;
    int                               n;
    int                               k;
    slot = 0;
    n = 0;
    case (w.command)
      cdt_pkg::CMD_ADD: begin
        if (tbl_count >= CAPACITY) begin
          expected_words.push_back(result_word(cdt_pkg::ST_FULL, '0, '0, '0, 1'b1));
        end else begin
          tbl_handle[tbl_count]   = w.handle;
          tbl_deadline[tbl_count] = w.deadline;
          tbl_count++;
          expected_words.push_back(result_word(cdt_pkg::ST_OK, '0, '0, '0, 1'b1));
        end
      end
      cdt_pkg::CMD_RM_HANDLE: begin
        while (slot < tbl_count && tbl_handle[slot] != w.handle) slot++;
        if (slot < tbl_count) begin
          remove_entry(slot);
        end else begin
          expected_words.push_back(result_word(cdt_pkg::ST_NOT_FOUND, '0, '0, '0,
                                               1'b1));
        end
      end
      cdt_pkg::CMD_NEAREST: begin
        if (tbl_count == 0) begin
          expected_words.push_back(result_word(cdt_pkg::ST_EMPTY, '0, '0,
                                               cdt_pkg::TMO_EMPTY, 1'b1));
        end else begin
          earliest = tbl_deadline[0];
          for (k = 1; k < tbl_count; k++) begin
            if (tbl_deadline[k] < earliest) earliest = tbl_deadline[k];
          end
          tmo = '0;
          if (earliest > w.now) begin
            gap_ms = 64'(earliest - w.now) * 64'(cdt_pkg::MS_PER_S);
            tmo = (gap_ms > 64'(cdt_pkg::TIMEOUT_TOP)) ? cdt_pkg::TIMEOUT_TOP :
                                                         gap_ms[cdt_pkg::TMO_W-1:0];
          end
          expected_words.push_back(result_word(cdt_pkg::ST_OK, '0, '0, tmo, 1'b1));
        end
      end
      cdt_pkg::CMD_SWEEP: begin
        // An expired slot is refilled from the end and looked at again.
        while (slot < tbl_count && n < cdt_pkg::MAX_RESULTS) begin
          if (tbl_deadline[slot] <= w.now) begin
            swept_h[n] = tbl_handle[slot];
            swept_d[n] = tbl_deadline[slot];
            n++;
            vacate(slot);
          end else begin
            slot++;
          end
        end
        if (n == 0) begin
          expected_words.push_back(result_word(cdt_pkg::ST_NONE_EXP, '0, '0, '0,
                                               1'b1));
        end else begin
          for (k = 0; k < n; k++) begin
            expected_words.push_back(result_word(cdt_pkg::ST_OK, swept_h[k],
                                                 swept_d[k], '0, k == n - 1));
          end
        end
      end
      cdt_pkg::CMD_RM_AT: begin
        if (w.position < tbl_count) begin
          remove_entry(32'(w.position));
        end else begin
          expected_words.push_back(result_word(cdt_pkg::ST_NOT_FOUND, '0, '0, '0,
                                               1'b1));
        end
      end
      default: begin
        expected_words.push_back(result_word(cdt_pkg::ST_NOT_FOUND, '0, '0, '0,
                                             1'b1));
      end
    endcase
  endtask

  task automatic check_word(input cdt_pkg::out_word_t got);
    cdt_pkg::out_word_t want;
    if (expected_words.size() == 0) begin
      flag_error($sformatf("unexpected word status=%0d handle=%h", got.status,
                           got.found_handle));
    end else begin
      want = expected_words.pop_front();
      if (got.status !== want.status)
        flag_error($sformatf("status %0d, expected %0d", got.status, want.status));
      if (got.found_handle !== want.found_handle)
        flag_error($sformatf("found_handle %h, expected %h", got.found_handle,
                             want.found_handle));
      if (got.found_deadline !== want.found_deadline)
        flag_error($sformatf("found_deadline %h, expected %h", got.found_deadline,
                             want.found_deadline));
      if (got.wait_ms !== want.wait_ms)
        flag_error($sformatf("wait_ms %0d, expected %0d", got.wait_ms,
                             want.wait_ms));
      if (got.last !== want.last)
        flag_error($sformatf("last %b, expected %b", got.last, want.last));
    end
  endtask

  // Monitor: check each result word taken, then predict from each command word taken.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) check_word(out_word);
      if (in_valid && !in_stall) table_apply(in_word);
    end
    in_taken <= rst_n && in_valid && !in_stall;
  end

  // Driver: a word stays on the port until it is taken.
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      if (cmd_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_word  <= cmd_queue.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, or a long hold-off when one is requested.
  always @(negedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_LEN;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  task automatic queue_cmd(input logic [cdt_pkg::CMD_W-1:0]  cmd,
                           input logic [cdt_pkg::HDL_W-1:0]  h,
                           input logic [cdt_pkg::TIME_W-1:0] d,
                           input logic [cdt_pkg::TIME_W-1:0] t,
                           input logic [cdt_pkg::POS_W-1:0]  pos);
    cdt_pkg::in_word_t w;
    w.command  = cmd;
    w.handle   = h;
    w.deadline = d;
    w.now      = t;
    w.position = pos;
    cmd_queue.push_back(w);
  endtask

  // Random commands; fields a command ignores carry random bits.
  // Handles come mostly from a small pool so searches hit, and duplicates occur.
  task automatic queue_random(input int count, input int add_pct);
    cdt_pkg::in_word_t w;
    int                pick;
    repeat (count) begin
      w.command  = cdt_pkg::CMD_ADD;
      w.handle   = cdt_pkg::HDL_W'($urandom);
      w.deadline = $urandom;
      w.now      = $urandom;
      w.position = cdt_pkg::POS_W'($urandom);
      sim_now    = sim_now + $urandom_range(0, 3);
      pick       = $urandom_range(0, 99);
      if (pick < add_pct) begin
        w.command = cdt_pkg::CMD_ADD;
        if ($urandom_range(0, 3) != 0)
          w.handle = cdt_pkg::HDL_W'($urandom_range(0, HANDLE_POOL));
        if ($urandom_range(0, 9) != 0) w.deadline = sim_now + $urandom_range(0, 30);
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 25) begin
          w.command = cdt_pkg::CMD_RM_HANDLE;
          if ($urandom_range(0, 3) != 0)
            w.handle = cdt_pkg::HDL_W'($urandom_range(0, HANDLE_POOL));
        end else if (pick < 45) begin
          w.command = cdt_pkg::CMD_RM_AT;
          if ($urandom_range(0, 3) != 0)
            w.position = cdt_pkg::POS_W'($urandom_range(0, CAPACITY - 1));
        end else if (pick < 68) begin
          w.command = cdt_pkg::CMD_NEAREST;
          if ($urandom_range(0, 9) != 0) w.now = sim_now;
        end else if (pick < 94) begin
          w.command = cdt_pkg::CMD_SWEEP;
          if ($urandom_range(0, 9) != 0) w.now = sim_now;
        end else begin
          w.command = cdt_pkg::CMD_W'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
        end
      end
      cmd_queue.push_back(w);
    end
  endtask

  task automatic wait_drained();
    @(posedge clk);
    while (cmd_queue.size() != 0 || in_valid || expected_words.size() != 0) begin
      @(posedge clk);
    end
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty table, extremes, duplicates, a deadline equal to now, spare codes.
    queue_cmd(cdt_pkg::CMD_NEAREST, '0, '0, '0, '0);
    queue_cmd(cdt_pkg::CMD_SWEEP, '0, '0, TIME_MAX, '0);
    queue_cmd(cdt_pkg::CMD_RM_HANDLE, '0, '0, '0, '0);
    queue_cmd(cdt_pkg::CMD_RM_AT, '0, '0, '0, '0);
    queue_cmd(cdt_pkg::CMD_ADD, '0, '0, '0, '0);
    queue_cmd(cdt_pkg::CMD_ADD, HDL_MAX, TIME_MAX, '0, '0);
    queue_cmd(cdt_pkg::CMD_ADD, 16'h1234, 32'd100, '0, '0);
    queue_cmd(cdt_pkg::CMD_ADD, 16'h1234, 32'd200, '0, '0);
    queue_cmd(cdt_pkg::CMD_NEAREST, '0, '0, '0, '0);
    queue_cmd(cdt_pkg::CMD_RM_AT, '0, '0, '0, '0);
    queue_cmd(cdt_pkg::CMD_NEAREST, '0, '0, 32'd50, '0);
    queue_cmd(cdt_pkg::CMD_NEAREST, '0, '0, '0, '0);
    queue_cmd(cdt_pkg::CMD_RM_HANDLE, 16'h1234, '0, '0, '0);
    queue_cmd(cdt_pkg::CMD_RM_HANDLE, 16'h1234, '0, '0, '0);
    queue_cmd(cdt_pkg::CMD_NEAREST, '0, '0, '0, '0);
    queue_cmd(cdt_pkg::CMD_NEAREST, '0, '0, TIME_MAX, '0);
    queue_cmd(cdt_pkg::CMD_RM_AT, '0, '0, '0, '1);
    queue_cmd(CMD_SPARE_LO, HDL_MAX, TIME_MAX, TIME_MAX, '1);
    queue_cmd(CMD_SPARE_LO + 3'd1, '0, '0, '0, '0);
    queue_cmd(CMD_SPARE_HI, '0, '0, '0, '0);
    queue_cmd(cdt_pkg::CMD_ADD, 16'd9, 32'd10, '0, '0);
    queue_cmd(cdt_pkg::CMD_SWEEP, '0, '0, 32'd9, '0);
    queue_cmd(cdt_pkg::CMD_SWEEP, '0, '0, 32'd10, '0);
    queue_cmd(cdt_pkg::CMD_SWEEP, '0, '0, TIME_MAX, '0);
    wait_drained();

    // Long receiver hold-off while the table is overfilled, then one full sweep.
    hold_req++;
    repeat (CAPACITY + 4) begin
      queue_cmd(cdt_pkg::CMD_ADD, cdt_pkg::HDL_W'($urandom), $urandom, $urandom,
                cdt_pkg::POS_W'($urandom));
    end
    queue_cmd(cdt_pkg::CMD_SWEEP, cdt_pkg::HDL_W'($urandom), $urandom, TIME_MAX,
              cdt_pkg::POS_W'($urandom));
    wait_drained();

    // Random phases, each with a different mix of sender gaps and receiver stalls.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
        default: begin send_idle_pct = 28; recv_stall_pct = 28; end
      endcase
      queue_random(15, 90);
      queue_random(20, 40);
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_words.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
